>>> hdl/kts_pkg.sv
// Shared constants and types of the keyframe track sampler.
`timescale 1ns / 1ps
package kts_pkg;
	localparam int Nodes     = 16;
	localparam int Keys      = 32;
	localparam int Channels  = 3;
	localparam int Tracks    = Nodes * Channels;
	localparam int Slots     = Tracks * Keys;
	localparam int TRACK_AW  = $clog2(Tracks);
	localparam int SLOT_AW   = $clog2(Slots);
	localparam int CNT_W     = $clog2(Keys + 1);
	localparam int KEY_W     = 128;
	localparam int FRAC_BITS = 17;

	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_LAST,
		PH_SCAN
	} phase_t;
endpackage

>>> hdl/keyframe_track_lerp_sampler_core.sv
// Keyframe track store with sorted insert and linear interpolation sampling.
//
//  channel  dir  signals                      payload
//  s        in   s_tvalid s_tready s_tdata    node, channel, key_time, value_xyz, default_xyz
//                s_tuser                      action
//  m        out  m_tvalid m_tready m_tdata    out_x, out_y, out_z, node_present, track_full
//
// One item at a time. An add reads and checks keys from the end of the track, moving
// each later key up one slot in the key RAM before writing the new one. A sample reads
// keys (first, last, then scan up to the segment), then runs 17 divider steps and the
// three multiply/add passes. Reset clears node-seen and track-count valid flops at once;
// the key RAM needs no clearing. A result waits in the output register until taken.
`timescale 1ns / 1ps
module keyframe_track_lerp_sampler_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// node[3:0], channel[5:4], key_time[37:6], value_x[69:38], value_y[101:70],
	// value_z[133:102], default_x[165:134], default_y[197:166], default_z[229:198]
	input  logic [231:0] s_tdata,
	// action[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64], node_present[96], track_full[97]
	output logic [103:0] m_tdata
);
	typedef enum logic [3:0] {
		S_IDLE, S_CNT, S_CNTD, S_ARD, S_ACHK, S_SRD, S_SCHK, S_DIV, S_MUL, S_ADD, S_DONE
	} state_t;

	state_t state_q;
	kts_pkg::phase_t ph_q;

	logic        act_q;
	logic [3:0]  node_q;
	logic [1:0]  chan_q;
	logic signed [31:0] tq_q;
	logic [31:0] val_q [3];
	logic [31:0] dflt_q [3];
	logic [kts_pkg::TRACK_AW-1:0] track_q;
	logic [kts_pkg::CNT_W-1:0] cnt_q, k_q;
	logic [31:0] prev_q [4];
	logic [31:0] cur_q [4];
	logic [31:0] res_q [3];
	logic        present_q, full_q;
	logic [33:0] rem_q;
	logic [32:0] span_q;
	logic [kts_pkg::FRAC_BITS-1:0] frac_q;
	logic [4:0]  step_q;
	logic [1:0]  comp_q;
	logic signed [50:0] prod_s1;
	logic [kts_pkg::Nodes-1:0]  seen_q;
	logic [kts_pkg::Tracks-1:0] cvalid_q;
	logic        m_valid_q;
	logic [103:0] m_data_q;

	// key RAM
	logic                        k_we;
	logic [kts_pkg::SLOT_AW-1:0] k_waddr, k_raddr;
	logic [kts_pkg::KEY_W-1:0]   k_wdata, k_rdata;
	// count RAM
	logic                         c_we;
	logic [kts_pkg::CNT_W-1:0]    c_rdata;

	kts_ram #(.Width(kts_pkg::KEY_W), .Depth(kts_pkg::Slots)) u_keys (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(k_raddr), .rdata(k_rdata)
	);

	kts_ram #(.Width(kts_pkg::CNT_W), .Depth(kts_pkg::Tracks)) u_counts (
		.clk(clk), .we(c_we), .waddr(track_q), .wdata(cnt_q + kts_pkg::CNT_W'(1)),
		.raddr(track_q), .rdata(c_rdata)
	);

	function automatic logic [kts_pkg::SLOT_AW-1:0] slot(
		input logic [kts_pkg::TRACK_AW-1:0] tr, input logic [kts_pkg::CNT_W-1:0] k);
		slot = kts_pkg::SLOT_AW'(tr) * kts_pkg::SLOT_AW'(kts_pkg::Keys) +
			kts_pkg::SLOT_AW'(k);
	endfunction

	logic signed [31:0] rd_t;
	logic node_ok, chan_ok, seen_now;
	logic [kts_pkg::CNT_W-1:0] cnt_rd;
	logic [kts_pkg::KEY_W-1:0] ins_key;
	logic [32:0] diff_w, span_w;
	logic signed [32:0] dlt_w;

	assign rd_t     = $signed(k_rdata[31:0]);
	assign node_ok  = 32'(node_q) < kts_pkg::Nodes;
	assign chan_ok  = 32'(chan_q) < kts_pkg::Channels;
	assign seen_now = node_ok && seen_q[node_q];
	assign cnt_rd   = cvalid_q[track_q] ? c_rdata : '0;
	assign ins_key  = {val_q[2], val_q[1], val_q[0], tq_q};
	// segment end time comes straight off the RAM read
	assign span_w   = 33'(rd_t) - 33'($signed(prev_q[0]));
	assign diff_w   = 33'(tq_q) - 33'($signed(prev_q[0]));
	assign dlt_w    = $signed(33'($signed(cur_q[comp_q + 2'd1]))) -
		$signed(33'($signed(prev_q[comp_q + 2'd1])));

	always_comb begin
		k_we    = 1'b0;
		k_waddr = slot(track_q, k_q);
		k_wdata = ins_key;
		k_raddr = slot(track_q, k_q);
		c_we    = 1'b0;
		case (state_q)
			S_ARD: begin
				k_raddr = slot(track_q, k_q - kts_pkg::CNT_W'(1));
				if (k_q == '0) begin
					k_we = 1'b1;
					c_we = 1'b1;
				end
			end
			S_ACHK: begin
				k_we = 1'b1;
				if (rd_t > tq_q) begin
					k_wdata = k_rdata;
				end else begin
					c_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ph_q      <= kts_pkg::PH_FIRST;
			seen_q    <= '0;
			cvalid_q  <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			act_q     <= 1'b0;
			node_q    <= '0;
			chan_q    <= '0;
			tq_q      <= '0;
			val_q     <= '{default: '0};
			dflt_q    <= '{default: '0};
			track_q   <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
			prev_q    <= '{default: '0};
			cur_q     <= '{default: '0};
			res_q     <= '{default: '0};
			present_q <= 1'b0;
			full_q    <= 1'b0;
			rem_q     <= '0;
			span_q    <= '0;
			frac_q    <= '0;
			step_q    <= '0;
			comp_q    <= '0;
			prod_s1   <= '0;
		end else begin
			if (m_valid_q && m_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end
			if (c_we) begin
				cvalid_q[track_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q     <= s_tuser;
						node_q    <= s_tdata[3:0];
						chan_q    <= s_tdata[5:4];
						tq_q      <= $signed(s_tdata[37:6]);
						val_q[0]  <= s_tdata[69:38];
						val_q[1]  <= s_tdata[101:70];
						val_q[2]  <= s_tdata[133:102];
						dflt_q[0] <= s_tdata[165:134];
						dflt_q[1] <= s_tdata[197:166];
						dflt_q[2] <= s_tdata[229:198];
						track_q   <= kts_pkg::TRACK_AW'(s_tdata[3:0] * 3 + s_tdata[5:4]);
						res_q     <= '{default: '0};
						full_q    <= 1'b0;
						state_q   <= S_CNT;
					end
				end
				S_CNT: state_q <= S_CNTD;
				S_CNTD: begin
					cnt_q <= cnt_rd;
					k_q   <= cnt_rd;
					if (act_q == kts_pkg::ACT_ADD) begin
						if (node_ok && chan_ok) begin
							seen_q[node_q] <= 1'b1;
							present_q      <= 1'b1;
							if (32'(cnt_rd) >= kts_pkg::Keys) begin
								full_q  <= 1'b1;
								state_q <= S_DONE;
							end else begin
								state_q <= S_ARD;
							end
						end else begin
							present_q <= seen_now;
							state_q   <= S_DONE;
						end
					end else begin
						present_q <= seen_now;
						if (!(seen_now && chan_ok) || cnt_rd == '0) begin
							res_q   <= dflt_q;
							state_q <= S_DONE;
						end else begin
							k_q     <= '0;
							ph_q    <= kts_pkg::PH_FIRST;
							state_q <= S_SRD;
						end
					end
				end
				S_ARD: begin
					state_q <= (k_q == '0) ? S_DONE : S_ACHK;
				end
				S_ACHK: begin
					if (rd_t > tq_q) begin
						k_q     <= k_q - kts_pkg::CNT_W'(1);
						state_q <= S_ARD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					case (ph_q)
						kts_pkg::PH_FIRST: begin
							prev_q <= '{k_rdata[31:0], k_rdata[63:32], k_rdata[95:64],
								k_rdata[127:96]};
							if (tq_q <= rd_t) begin
								res_q   <= '{k_rdata[63:32], k_rdata[95:64], k_rdata[127:96]};
								state_q <= S_DONE;
							end else begin
								k_q     <= cnt_q - kts_pkg::CNT_W'(1);
								ph_q    <= kts_pkg::PH_LAST;
								state_q <= S_SRD;
							end
						end
						kts_pkg::PH_LAST: begin
							if (tq_q >= rd_t) begin
								res_q   <= '{k_rdata[63:32], k_rdata[95:64], k_rdata[127:96]};
								state_q <= S_DONE;
							end else begin
								k_q     <= kts_pkg::CNT_W'(1);
								ph_q    <= kts_pkg::PH_SCAN;
								state_q <= S_SRD;
							end
						end
						default: begin
							if (rd_t >= tq_q) begin
								cur_q   <= '{k_rdata[31:0], k_rdata[63:32], k_rdata[95:64],
									k_rdata[127:96]};
								// span is never zero here: prev time < query <= this time
								span_q  <= span_w;
								rem_q   <= {1'b0, diff_w};
								step_q  <= 5'(kts_pkg::FRAC_BITS);
								frac_q  <= '0;
								state_q <= S_DIV;
							end else begin
								prev_q  <= '{k_rdata[31:0], k_rdata[63:32], k_rdata[95:64],
									k_rdata[127:96]};
								k_q     <= k_q + kts_pkg::CNT_W'(1);
								state_q <= S_SRD;
							end
						end
					endcase
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (rem_q >= {1'b0, span_q}) begin
						rem_q  <= {rem_q[32:0] - span_q, 1'b0};
						frac_q <= {frac_q[kts_pkg::FRAC_BITS-2:0], 1'b1};
					end else begin
						rem_q  <= {rem_q[32:0], 1'b0};
						frac_q <= {frac_q[kts_pkg::FRAC_BITS-2:0], 1'b0};
					end
					step_q <= step_q - 5'd1;
					if (step_q == 5'd1) begin
						comp_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_s1 <= 51'(dlt_w * $signed({1'b0, frac_q}));
					state_q <= S_ADD;
				end
				S_ADD: begin
					res_q[comp_q] <= prev_q[comp_q + 2'd1] + prod_s1[47:16];
					if (comp_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {6'd0, full_q, present_q, res_q[2], res_q[1], res_q[0]};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/kts_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module kts_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/kts_checker.sv
// Port-level checks of the keyframe track sampler, bound to the top level.
`timescale 1ns / 1ps
module kts_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [231:0] s_tdata,
	input logic         s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transfer taken while busy");

	a_full_present: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[97] |-> m_tdata[96])
		else $error("full track reported on unseen node");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[97] |-> m_tdata[95:0] == 96'd0)
		else $error("dropped add returned nonzero value");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[103:98] == 6'd0)
		else $error("padding bits set");
endmodule

bind keyframe_track_lerp_sampler_core kts_checker u_kts_checker (.*);
